// ----- sv/supervision_frame_receiver_unit_assert.svh -----
// assertion helpers, compiled away for synthesis
`ifndef SUPERVISION_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SUPERVISION_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SFR_ASSERT_IMP(label, clk, rst, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/sfr_pkg.sv -----
package sfr_pkg;

   localparam logic [7:0] FLAG_BYTE         = 8'h5C;
   localparam logic [7:0] OWN_ADDRESS_RESET = 8'h03;

   localparam logic [7:0] CTL_RR0  = 8'b0000_0001;
   localparam logic [7:0] CTL_RR1  = 8'b0001_0001;
   localparam logic [7:0] CTL_REJ0 = 8'b0000_0101;
   localparam logic [7:0] CTL_REJ1 = 8'b0001_0101;
   localparam logic [7:0] CTL_UA   = 8'h06;
   localparam logic [7:0] CTL_DISC = 8'h0A;

   // bit of the control byte that carries the sequence number
   localparam int SEQ_BIT = 4;

   typedef enum logic [2:0] {
      PHASE_START,
      PHASE_FLAG,
      PHASE_ADDR,
      PHASE_CTRL,
      PHASE_CHECK
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_SEQ,
      STATUS_ABORT,
      STATUS_BADC
   } status_type;

   typedef enum logic [1:0] {
      KIND_RR,
      KIND_REJ,
      KIND_UA,
      KIND_DISC
   } kind_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      kind_type   kind;
      logic       seq;
   } result_type;

endpackage

// ----- sv/sfr_req_if.sv -----
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- sv/sfr_rsp_if.sv -----
interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [1:0] frame_kind;
   logic       frame_seq;

   modport source (output valid, output status, output frame_kind, output frame_seq,
                   input ready);
   modport sink (input valid, input status, input frame_kind, input frame_seq,
                 output ready);
endinterface

// ----- sv/supervision_frame_receiver_unit.sv -----
// Supervision frame receiver. Takes one received byte per req_ch transaction and
// watches for the frame flag 0x5C, own address, control, check (address xor
// control), flag. A closing flag yields one rsp_ch transaction with the frame
// kind and either ok (the expected sequence bit then toggles) or sequence
// mismatch; a double flag yields an abort and an unknown control byte a bad
// control status. Bytes that break a frame silently restart the parser. One
// byte is taken every cycle: the parser is a single registered stage and its
// result lands in the output register the cycle after the byte that caused it.
// The input stalls only while a result sits in the output register and rsp_ch
// is not ready. csr_wr_data sets the own address (reset value 0x03).
`include "supervision_frame_receiver_unit_assert.svh"

module supervision_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   sfr_req_if.sink     req_ch,
   sfr_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0]           own_address_ff, own_address_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sfr_pkg::status_type  rsp_status_ff, rsp_status_in;
   sfr_pkg::kind_type    rsp_kind_ff, rsp_kind_in;
   logic                 rsp_seq_ff, rsp_seq_in;

   logic                 req_accept;
   sfr_pkg::result_type  result;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   sfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_byte     (req_ch.rx_byte),
      .own_address (own_address_ff),
      .result      (result)
   );

   assign own_address_in = csr_wr_en ? csr_wr_data : own_address_ff;

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_seq_in    = rsp_seq_ff;
      if (req_accept) begin
         rsp_valid_in = result.valid;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      end
      if (result.valid) begin
         rsp_status_in = result.status;
         rsp_kind_in   = result.kind;
         rsp_seq_in    = result.seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= sfr_pkg::OWN_ADDRESS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         own_address_ff <= own_address_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_seq_ff    <= rsp_seq_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.frame_kind = rsp_kind_ff;
   assign rsp_ch.frame_seq  = rsp_seq_ff;

   `SFR_ASSERT_NEXT(a_no_result_without_byte, clock, reset,
      !req_accept && !(rsp_valid_ff && !rsp_ch.ready), !rsp_valid_ff)
   `SFR_ASSERT_IMP(a_error_fields_clear, clock, reset,
      rsp_valid_ff && ((rsp_status_ff == sfr_pkg::STATUS_ABORT) ||
                       (rsp_status_ff == sfr_pkg::STATUS_BADC)),
      (rsp_kind_ff == sfr_pkg::KIND_RR) && !rsp_seq_ff)
   `SFR_ASSERT_IMP(a_unsequenced_seq_clear, clock, reset,
      rsp_valid_ff && ((rsp_kind_ff == sfr_pkg::KIND_UA) ||
                       (rsp_kind_ff == sfr_pkg::KIND_DISC)),
      !rsp_seq_ff && (rsp_status_ff == sfr_pkg::STATUS_OK))

endmodule

// ----- sv/sfr_parser.sv -----
`include "supervision_frame_receiver_unit_assert.svh"

module sfr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  logic [7:0]         own_address,
   output sfr_pkg::result_type result
);

   sfr_pkg::phase_type phase_ff, phase_in;
   logic               flag_run_ff, flag_run_in;
   logic [7:0]         held_control_ff, held_control_in;
   sfr_pkg::kind_type  held_kind_ff, held_kind_in;
   logic               held_seq_ff, held_seq_in;
   logic               expected_seq_ff, expected_seq_in;

   logic              is_flag;
   logic              abort;
   logic              ctl_known;
   sfr_pkg::kind_type ctl_kind;
   logic              seq_frame;
   logic              seq_match;
   logic              close_frame;

   assign is_flag = (rx_byte == sfr_pkg::FLAG_BYTE);
   // a flag right after a flag aborts, whatever the phase, unless the first one closed a frame or aborted
   assign abort   = is_flag && flag_run_ff;

   always_comb begin
      ctl_known = 1'b1;
      ctl_kind  = sfr_pkg::KIND_RR;
      case (rx_byte)
         sfr_pkg::CTL_RR0, sfr_pkg::CTL_RR1:   ctl_kind = sfr_pkg::KIND_RR;
         sfr_pkg::CTL_REJ0, sfr_pkg::CTL_REJ1: ctl_kind = sfr_pkg::KIND_REJ;
         sfr_pkg::CTL_UA:                      ctl_kind = sfr_pkg::KIND_UA;
         sfr_pkg::CTL_DISC:                    ctl_kind = sfr_pkg::KIND_DISC;
         default:                              ctl_known = 1'b0;
      endcase
   end

   assign seq_frame   = (held_kind_ff == sfr_pkg::KIND_RR) ||
                        (held_kind_ff == sfr_pkg::KIND_REJ);
   assign seq_match   = !seq_frame || (held_seq_ff == expected_seq_ff);
   assign close_frame = (phase_ff == sfr_pkg::PHASE_CHECK) && is_flag && !abort;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      flag_run_in     = flag_run_ff;
      held_control_in = held_control_ff;
      held_kind_in    = held_kind_ff;
      held_seq_in     = held_seq_ff;
      expected_seq_in = expected_seq_ff;
      if (accept) begin
         flag_run_in = is_flag;
         if (abort) begin
            phase_in    = sfr_pkg::PHASE_START;
            flag_run_in = 1'b0;
         end else begin
            case (phase_ff)
               sfr_pkg::PHASE_START: begin
                  if (is_flag) phase_in = sfr_pkg::PHASE_FLAG;
               end
               sfr_pkg::PHASE_FLAG: begin
                  phase_in = (rx_byte == own_address) ? sfr_pkg::PHASE_ADDR
                                                      : sfr_pkg::PHASE_START;
               end
               sfr_pkg::PHASE_ADDR: begin
                  if (ctl_known) begin
                     held_control_in = rx_byte;
                     held_kind_in    = ctl_kind;
                     held_seq_in     = ((ctl_kind == sfr_pkg::KIND_RR) ||
                                        (ctl_kind == sfr_pkg::KIND_REJ)) &&
                                       rx_byte[sfr_pkg::SEQ_BIT];
                     phase_in        = sfr_pkg::PHASE_CTRL;
                  end else if (is_flag) begin
                     phase_in = sfr_pkg::PHASE_FLAG;
                  end else begin
                     phase_in = sfr_pkg::PHASE_START;
                  end
               end
               sfr_pkg::PHASE_CTRL: begin
                  phase_in = (rx_byte == (own_address ^ held_control_ff))
                             ? sfr_pkg::PHASE_CHECK : sfr_pkg::PHASE_START;
               end
               sfr_pkg::PHASE_CHECK: begin
                  phase_in = sfr_pkg::PHASE_START;
                  if (is_flag) begin
                     flag_run_in = 1'b0;
                     if (seq_match) expected_seq_in = !expected_seq_ff;
                  end
               end
               default: phase_in = sfr_pkg::PHASE_START;
            endcase
         end
      end
   end

   // result of the current byte
   always_comb begin
      result.valid  = 1'b0;
      result.status = sfr_pkg::STATUS_OK;
      result.kind   = sfr_pkg::KIND_RR;
      result.seq    = 1'b0;
      if (accept) begin
         if (abort) begin
            result.valid  = 1'b1;
            result.status = sfr_pkg::STATUS_ABORT;
         end else if ((phase_ff == sfr_pkg::PHASE_ADDR) && !ctl_known && !is_flag) begin
            result.valid  = 1'b1;
            result.status = sfr_pkg::STATUS_BADC;
         end else if (close_frame) begin
            result.valid  = 1'b1;
            result.status = seq_match ? sfr_pkg::STATUS_OK : sfr_pkg::STATUS_SEQ;
            result.kind   = held_kind_ff;
            result.seq    = seq_frame && held_seq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sfr_pkg::PHASE_START;
         flag_run_ff     <= 1'b0;
         expected_seq_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         flag_run_ff     <= flag_run_in;
         expected_seq_ff <= expected_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      held_control_ff <= held_control_in;
      held_kind_ff    <= held_kind_in;
      held_seq_ff     <= held_seq_in;
   end

   `SFR_ASSERT_NEXT(a_restart_after_result, clock, reset, result.valid,
      (phase_ff == sfr_pkg::PHASE_START) && !flag_run_ff)
   `SFR_ASSERT_IMP(a_seq_toggles_on_ok, clock, reset, !$stable(expected_seq_ff),
      $past(reset) || $past(result.valid && (result.status == sfr_pkg::STATUS_OK)))

endmodule

// ----- test/supervision_frame_receiver_unit_test.sv -----
`timescale 1ns / 1ps

module supervision_frame_receiver_unit_test;

   typedef struct {
      sfr_pkg::status_type status;
      sfr_pkg::kind_type   kind;
      logic                seq;
   } frame_report_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   sfr_req_if req_ch ();
   sfr_rsp_if rsp_ch ();

   supervision_frame_receiver_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // receiver model state
   sfr_pkg::phase_type parse_phase_q;
   logic [1:0]         flag_count;
   logic [7:0]         held_ctl;
   sfr_pkg::kind_type  held_kind_q;
   logic               held_seq_q;
   logic               next_seq;
   logic [7:0]         own_addr;

   frame_report_type reports_due[$];

   int send_idle_pct;
   int rsp_idle_pct;
   int stall_left;
   int error_count;
   int bytes_sent;

   logic [7:0] ctl_codes[6] = '{sfr_pkg::CTL_RR0, sfr_pkg::CTL_RR1, sfr_pkg::CTL_REJ0,
                                sfr_pkg::CTL_REJ1, sfr_pkg::CTL_UA, sfr_pkg::CTL_DISC};

   function void push_report(sfr_pkg::status_type s, sfr_pkg::kind_type k, logic q);
      frame_report_type r;
      r.status = s;
      r.kind = k;
      r.seq = q;
      reports_due.push_back(r);
      parse_phase_q = sfr_pkg::PHASE_START;
      flag_count = 2'd0;
   endfunction

   function void track_byte(logic [7:0] b);
      logic is_flag;
      logic known;
      logic seq_frame;
      is_flag = (b == sfr_pkg::FLAG_BYTE);
      flag_count = is_flag ? flag_count + 2'd1 : 2'd0;
      // two flags in a row abort whatever phase we are in, unless the first one closed a frame or aborted
      if (flag_count >= 2'd2) begin
         push_report(sfr_pkg::STATUS_ABORT, sfr_pkg::KIND_RR, 1'b0);
         return;
      end
      case (parse_phase_q)
         sfr_pkg::PHASE_START: begin
            if (is_flag) parse_phase_q = sfr_pkg::PHASE_FLAG;
         end
         sfr_pkg::PHASE_FLAG: begin
            parse_phase_q = (b == own_addr) ? sfr_pkg::PHASE_ADDR : sfr_pkg::PHASE_START;
         end
         sfr_pkg::PHASE_ADDR: begin
            known = 1'b1;
            case (b)
               sfr_pkg::CTL_RR0, sfr_pkg::CTL_RR1: begin
                  held_kind_q = sfr_pkg::KIND_RR;
                  held_seq_q = b[sfr_pkg::SEQ_BIT];
               end
               sfr_pkg::CTL_REJ0, sfr_pkg::CTL_REJ1: begin
                  held_kind_q = sfr_pkg::KIND_REJ;
                  held_seq_q = b[sfr_pkg::SEQ_BIT];
               end
               sfr_pkg::CTL_UA: begin
                  held_kind_q = sfr_pkg::KIND_UA;
                  held_seq_q = 1'b0;
               end
               sfr_pkg::CTL_DISC: begin
                  held_kind_q = sfr_pkg::KIND_DISC;
                  held_seq_q = 1'b0;
               end
               default: known = 1'b0;
            endcase
            if (known) begin
               held_ctl = b;
               parse_phase_q = sfr_pkg::PHASE_CTRL;
            end else if (is_flag) begin
               parse_phase_q = sfr_pkg::PHASE_FLAG;
            end else begin
               push_report(sfr_pkg::STATUS_BADC, sfr_pkg::KIND_RR, 1'b0);
            end
         end
         sfr_pkg::PHASE_CTRL: begin
            parse_phase_q = (b == (own_addr ^ held_ctl)) ? sfr_pkg::PHASE_CHECK
                                                         : sfr_pkg::PHASE_START;
         end
         sfr_pkg::PHASE_CHECK: begin
            if (is_flag) begin
               seq_frame = (held_kind_q == sfr_pkg::KIND_RR) ||
                           (held_kind_q == sfr_pkg::KIND_REJ);
               if (seq_frame && held_seq_q != next_seq) begin
                  push_report(sfr_pkg::STATUS_SEQ, held_kind_q, held_seq_q);
               end else begin
                  next_seq = ~next_seq;
                  push_report(sfr_pkg::STATUS_OK, held_kind_q,
                              seq_frame ? held_seq_q : 1'b0);
               end
            end else begin
               parse_phase_q = sfr_pkg::PHASE_START;
            end
         end
         default: parse_phase_q = sfr_pkg::PHASE_START;
      endcase
   endfunction

   task check_report();
      frame_report_type want;
      if (reports_due.size() == 0) begin
         $error("unexpected result status %0d kind %0d seq %0d",
                rsp_ch.status, rsp_ch.frame_kind, rsp_ch.frame_seq);
         error_count++;
      end else begin
         want = reports_due.pop_front();
         if (rsp_ch.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp_ch.status);
            error_count++;
         end
         if (rsp_ch.frame_kind !== want.kind) begin
            $error("frame_kind expected %0d actual %0d", want.kind, rsp_ch.frame_kind);
            error_count++;
         end
         if (rsp_ch.frame_seq !== want.seq) begin
            $error("frame_seq expected %0d actual %0d", want.seq, rsp_ch.frame_seq);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_report();
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      track_byte(b);
      bytes_sent++;
   endtask

   task send_frame(input logic [7:0] addr, input logic [7:0] ctl,
                   input logic [7:0] chk, input logic [7:0] close);
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(addr);
      send_byte(ctl);
      send_byte(chk);
      send_byte(close);
   endtask

   task send_good_frame(input logic [7:0] ctl);
      send_frame(own_addr, ctl, own_addr ^ ctl, sfr_pkg::FLAG_BYTE);
   endtask

   task wait_drained();
      req_ch.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
   endtask

   task set_own_address(input logic [7:0] value);
      wait_drained();
      // a byte that produced no result may still be in the parser stage
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      own_addr = value;
   endtask

   task test_control_kinds();
      send_good_frame(sfr_pkg::CTL_RR0);
      send_good_frame(sfr_pkg::CTL_REJ1);
      send_good_frame(sfr_pkg::CTL_UA);
      send_good_frame(sfr_pkg::CTL_DISC);
      send_good_frame(sfr_pkg::CTL_RR1);   // sequence mismatch
      send_good_frame(sfr_pkg::CTL_REJ0);
   endtask

   task test_frame_errors();
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(sfr_pkg::FLAG_BYTE);
      // unknown control byte
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(own_addr);
      send_byte(8'h00);
      // flag in address phase, then a second flag aborts
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(own_addr);
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(sfr_pkg::FLAG_BYTE);
      // wrong address
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(8'hFF);
      // wrong check, flag in control phase, non-flag after good check
      send_frame(own_addr, sfr_pkg::CTL_UA, 8'h00, 8'hFF);
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(own_addr);
      send_byte(sfr_pkg::CTL_UA);
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(8'h00);
      send_frame(own_addr, sfr_pkg::CTL_DISC, own_addr ^ sfr_pkg::CTL_DISC, 8'hFF);
   endtask

   task test_address_extremes();
      set_own_address(8'h00);
      send_good_frame(sfr_pkg::CTL_DISC);
      send_good_frame(next_seq ? sfr_pkg::CTL_RR1 : sfr_pkg::CTL_RR0);
      set_own_address(8'hFF);
      send_good_frame(next_seq ? sfr_pkg::CTL_REJ1 : sfr_pkg::CTL_REJ0);
      // address equal to the flag can only ever abort
      set_own_address(sfr_pkg::FLAG_BYTE);
      send_byte(sfr_pkg::FLAG_BYTE);
      send_byte(sfr_pkg::FLAG_BYTE);
   endtask

   task test_random_mix(input int count);
      int target;
      int pick;
      logic [7:0] addr;
      logic [7:0] ctl;
      logic [7:0] chk;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_good_frame(ctl_codes[3'($urandom_range(5))]);
         end else if (pick < 85) begin
            addr = $urandom_range(1) ? own_addr : 8'($urandom_range(255));
            ctl = $urandom_range(1) ? ctl_codes[3'($urandom_range(5))]
                                    : 8'($urandom_range(255));
            chk = $urandom_range(1) ? (addr ^ ctl) : 8'($urandom_range(255));
            send_frame(addr, ctl, chk,
                       $urandom_range(1) ? sfr_pkg::FLAG_BYTE : 8'($urandom_range(255)));
         end else if (pick < 93) begin
            send_byte(8'($urandom_range(255)));
         end else begin
            send_byte(sfr_pkg::FLAG_BYTE);
         end
      end
   endtask

   task test_backpressure();
      // long receiver hold-off while frames keep coming
      stall_left = 400;
      repeat (20) send_good_frame(ctl_codes[3'($urandom_range(5))]);
      while (stall_left > 0) @(posedge clock);
      wait_drained();
      repeat (10) send_good_frame(ctl_codes[3'($urandom_range(5))]);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      parse_phase_q = sfr_pkg::PHASE_START;
      flag_count = 2'd0;
      held_ctl = 8'h00;
      held_kind_q = sfr_pkg::KIND_RR;
      held_seq_q = 1'b0;
      next_seq = 1'b0;
      own_addr = sfr_pkg::OWN_ADDRESS_RESET;
      stall_left = 0;
      error_count = 0;
      bytes_sent = 0;
      send_idle_pct = 33;
      rsp_idle_pct = 79;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_control_kinds();
      test_frame_errors();
      test_address_extremes();
      set_own_address(8'($urandom_range(255)));
      test_random_mix(650);

      send_idle_pct = 79;
      rsp_idle_pct = 33;
      set_own_address(8'($urandom_range(255)));
      test_random_mix(650);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      set_own_address(sfr_pkg::OWN_ADDRESS_RESET);
      test_backpressure();
      set_own_address(8'($urandom_range(255)));
      test_random_mix(450);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/sfr_pkg.sv
sv/sfr_req_if.sv
sv/sfr_rsp_if.sv
sv/sfr_parser.sv
sv/supervision_frame_receiver_unit.sv
test/supervision_frame_receiver_unit_test.sv
